@@ design/smd5_pkg.sv @@
// Shared types, constants and round functions for the serial MD5 key derivation block.
// No dependencies; smd5_compress, the key derivation core and the dv files import it.
`timescale 1ns / 1ps
package smd5_pkg;

  localparam int WORD_W    = 32;
  localparam int BUF_WORDS = 16;
  localparam int BUF_AW    = $clog2(BUF_WORDS);
  localparam int CNT_W     = 16;

  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;
  localparam logic [7:0] UPPER_LO  = 8'h41;
  localparam logic [7:0] UPPER_HI  = 8'h5A;
  localparam logic [7:0] LOWER_LO  = 8'h61;
  localparam logic [7:0] LOWER_HI  = 8'h7A;
  localparam logic [7:0] UPPER_OFS = 8'h37;
  localparam logic [7:0] LOWER_OFS = 8'h57;
  localparam logic [7:0] IV_MUL    = 8'd17;
  localparam logic [7:0] IV_ADD    = 8'h13;
  localparam logic [7:0] KEY_MUL   = 8'd13;
  localparam logic [7:0] KEY_ADD   = 8'd61;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam logic [BUF_AW-1:0] LEN_WORD  = BUF_AW'(14);
  localparam logic [BUF_AW-1:0] LAST_WORD = BUF_AW'(BUF_WORDS - 1);

  typedef logic [3:0][WORD_W-1:0] chain_t;

  localparam chain_t MD5_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
    logic        length_overflow;
  } out_item_t;

  typedef struct packed {
    logic start;
  } cmp_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              rd_en;
    logic [BUF_AW-1:0] rd_addr;
  } cmp_stat_t;

  // Map a serial character to its value, then apply the selected affine transform.
  function automatic logic [7:0] smd5_xform(input logic [7:0] ch, input logic key_mode);
    logic [7:0] v;
    v = ch;
    if (ch >= DIGIT_LO && ch <= DIGIT_HI) v = ch - DIGIT_LO;
    else if (ch >= UPPER_LO && ch <= UPPER_HI) v = ch - UPPER_OFS;
    else if (ch >= LOWER_LO && ch <= LOWER_HI) v = ch - LOWER_OFS;
    if (key_mode) return 8'(v * KEY_MUL + KEY_ADD);
    else return 8'(v * IV_MUL + IV_ADD);
  endfunction

  // Message word index used by round i.
  function automatic logic [BUF_AW-1:0] smd5_g(input logic [5:0] i);
    logic [3:0] lo;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    return lo;
      2'd1:    return 4'(lo * 4'd5 + 4'd1);
      2'd2:    return 4'(lo * 4'd3 + 4'd5);
      default: return 4'(lo * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] smd5_rot(input logic [5:0] i);
    case ({i[5:4], i[1:0]})
      4'd0:    return 5'd7;
      4'd1:    return 5'd12;
      4'd2:    return 5'd17;
      4'd3:    return 5'd22;
      4'd4:    return 5'd5;
      4'd5:    return 5'd9;
      4'd6:    return 5'd14;
      4'd7:    return 5'd20;
      4'd8:    return 5'd4;
      4'd9:    return 5'd11;
      4'd10:   return 5'd16;
      4'd11:   return 5'd23;
      4'd12:   return 5'd6;
      4'd13:   return 5'd10;
      4'd14:   return 5'd15;
      default: return 5'd21;
    endcase
  endfunction

  function automatic logic [31:0] smd5_k(input logic [5:0] i);
    case (i)
      6'd0:  return 32'hd76aa478;  6'd1:  return 32'he8c7b756;
      6'd2:  return 32'h242070db;  6'd3:  return 32'hc1bdceee;
      6'd4:  return 32'hf57c0faf;  6'd5:  return 32'h4787c62a;
      6'd6:  return 32'ha8304613;  6'd7:  return 32'hfd469501;
      6'd8:  return 32'h698098d8;  6'd9:  return 32'h8b44f7af;
      6'd10: return 32'hffff5bb1;  6'd11: return 32'h895cd7be;
      6'd12: return 32'h6b901122;  6'd13: return 32'hfd987193;
      6'd14: return 32'ha679438e;  6'd15: return 32'h49b40821;
      6'd16: return 32'hf61e2562;  6'd17: return 32'hc040b340;
      6'd18: return 32'h265e5a51;  6'd19: return 32'he9b6c7aa;
      6'd20: return 32'hd62f105d;  6'd21: return 32'h02441453;
      6'd22: return 32'hd8a1e681;  6'd23: return 32'he7d3fbc8;
      6'd24: return 32'h21e1cde6;  6'd25: return 32'hc33707d6;
      6'd26: return 32'hf4d50d87;  6'd27: return 32'h455a14ed;
      6'd28: return 32'ha9e3e905;  6'd29: return 32'hfcefa3f8;
      6'd30: return 32'h676f02d9;  6'd31: return 32'h8d2a4c8a;
      6'd32: return 32'hfffa3942;  6'd33: return 32'h8771f681;
      6'd34: return 32'h6d9d6122;  6'd35: return 32'hfde5380c;
      6'd36: return 32'ha4beea44;  6'd37: return 32'h4bdecfa9;
      6'd38: return 32'hf6bb4b60;  6'd39: return 32'hbebfbc70;
      6'd40: return 32'h289b7ec6;  6'd41: return 32'heaa127fa;
      6'd42: return 32'hd4ef3085;  6'd43: return 32'h04881d05;
      6'd44: return 32'hd9d4d039;  6'd45: return 32'he6db99e5;
      6'd46: return 32'h1fa27cf8;  6'd47: return 32'hc4ac5665;
      6'd48: return 32'hf4292244;  6'd49: return 32'h432aff97;
      6'd50: return 32'hab9423a7;  6'd51: return 32'hfc93a039;
      6'd52: return 32'h655b59c3;  6'd53: return 32'h8f0ccc92;
      6'd54: return 32'hffeff47d;  6'd55: return 32'h85845dd1;
      6'd56: return 32'h6fa87e4f;  6'd57: return 32'hfe2ce6e0;
      6'd58: return 32'ha3014314;  6'd59: return 32'h4e0811a1;
      6'd60: return 32'hf7537e82;  6'd61: return 32'hbd3af235;
      6'd62: return 32'h2ad7d2bb;  default: return 32'heb86d391;
    endcase
  endfunction

endpackage

@@ design/smd5_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module smd5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ design/smd5_compress.sv @@
// MD5 compression unit: 64 rounds (add, then rotate), reading one message word per round.
// Depends on smd5_pkg; message words come from the block buffer RAM in the top level.
`timescale 1ns / 1ps
module smd5_compress
  import smd5_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmp_ctl_t          ctl,
  input  chain_t            chain_in,
  input  logic [WORD_W-1:0] rdata,
  output cmp_stat_t         stat,
  output chain_t            sum
);

  typedef enum logic [1:0] {C_IDLE, C_ADD, C_ROT, C_FIN} cst_t;

  cst_t              st_r;
  logic [5:0]        rnd_r;
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r, s_r;
  logic [WORD_W-1:0] f;
  logic [63:0]       rot_w;

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign rot_w = {s_r, s_r} << smd5_rot(rnd_r);

  // Read round 0's word on start, then the next one in every rotate phase but the last.
  assign stat.rd_en   = (st_r == C_IDLE && ctl.start) || (st_r == C_ROT && rnd_r != 6'd63);
  assign stat.rd_addr = (st_r == C_IDLE) ? '0 : smd5_g(rnd_r + 6'd1);
  assign stat.done    = (st_r == C_FIN);
  assign stat.busy    = (st_r != C_IDLE);

  assign sum[0] = chain_in[0] + a_r;
  assign sum[1] = chain_in[1] + b_r;
  assign sum[2] = chain_in[2] + c_r;
  assign sum[3] = chain_in[3] + d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      rnd_r <= '0;
    end else begin
      unique case (st_r)
        C_IDLE: begin
          if (ctl.start) begin
            a_r   <= chain_in[0];
            b_r   <= chain_in[1];
            c_r   <= chain_in[2];
            d_r   <= chain_in[3];
            rnd_r <= '0;
            st_r  <= C_ADD;
          end
        end
        C_ADD: begin
          s_r  <= a_r + f + smd5_k(rnd_r) + rdata;
          st_r <= C_ROT;
        end
        C_ROT: begin
          a_r   <= d_r;
          d_r   <= c_r;
          c_r   <= b_r;
          b_r   <= b_r + rot_w[63:32];
          rnd_r <= rnd_r + 6'd1;
          st_r  <= (rnd_r == 6'd63) ? C_FIN : C_ADD;
        end
        C_FIN: begin
          st_r <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

endmodule

@@ design/serial_md5_key_derive_core.sv @@
// Serial-number key derivation: maps and transforms each character, streams it into MD5.
// Depends on smd5_pkg, smd5_ram (block buffer) and smd5_compress (round unit).
//
// A character beat is taken whenever the block is idle. The buffer is a 16 x 32-bit RAM
// filled one word per four characters; each 64th character starts a compression that
// keeps the input stalled while the shared round unit runs all 64 rounds, plus the
// chaining add. On the last character the padding is written one word per cycle and
// compressed, and a second padding block follows when the message leaves one to eight
// bytes free in its last block. The digest sits in an output register, so the next
// serial streams in while it waits to be taken.
// derive_mode is written through the cfg port and takes effect from the next character.
`timescale 1ns / 1ps
module serial_md5_key_derive_core
  import smd5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_derive_mode
);

  typedef enum logic [1:0] {S_IDLE, S_PADW, S_CMP, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              mode_r, mode_nxt;
  chain_t            chain_r, chain_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [BUF_AW-1:0] pad_idx_r, pad_idx_nxt;
  logic              pad_first_r, pad_first_nxt;
  logic              len_phase_r, len_phase_nxt;
  logic              pad_mode_r, pad_mode_nxt;
  logic              finishing_r, finishing_nxt;
  logic              final_blk_r, final_blk_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              in_acc;
  logic [7:0]        xbyte;
  logic [CNT_W-1:0]  cnt_inc;
  logic [1:0]        lane;
  logic [WORD_W-1:0] pad_word;
  logic [WORD_W-1:0] len_word;

  logic              ram_we;
  logic [BUF_AW-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  cmp_ctl_t          cmp_ctl;
  cmp_stat_t         cmp_stat;
  chain_t            cmp_sum;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_acc  = in_valid && in_ready;
  assign xbyte   = smd5_xform(in_data.char_byte, mode_r);
  assign cnt_inc = byte_count_r + CNT_W'(1);
  assign lane    = byte_count_r[1:0];
  assign len_word = {{(WORD_W - CNT_W - 3){1'b0}}, byte_count_r, 3'd0};

  // First padding word: keep the message bytes below the end, then 0x80, then zeros.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < lane) pad_word[8*k +: 8] = word_r[8*k +: 8];
      else if (2'(k) == lane) pad_word[8*k +: 8] = PAD_BYTE;
      else pad_word[8*k +: 8] = 8'd0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = byte_count_r[5:2];
    ram_wdata = {xbyte, word_r[23:0]};
    if (state_r == S_PADW) begin
      ram_we    = 1'b1;
      ram_waddr = pad_idx_r;
      if (pad_first_r) ram_wdata = pad_word;
      else if (len_phase_r && pad_idx_r == LEN_WORD) ram_wdata = len_word;
      else ram_wdata = '0;
    end else if (in_acc && lane == 2'd3) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    ovf_nxt        = ovf_r;
    mode_nxt       = mode_r;
    chain_nxt      = chain_r;
    word_nxt       = word_r;
    pad_idx_nxt    = pad_idx_r;
    pad_first_nxt  = pad_first_r;
    len_phase_nxt  = len_phase_r;
    pad_mode_nxt   = pad_mode_r;
    finishing_nxt  = finishing_r;
    final_blk_nxt  = final_blk_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    cmp_ctl.start  = 1'b0;

    if (cfg_valid && cfg_ready) mode_nxt = cfg_derive_mode;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_count_nxt = cnt_inc;
          if (byte_count_r == '1) ovf_nxt = 1'b1;
          word_nxt[{lane, 3'd0} +: 8] = xbyte;
          if (cnt_inc[5:0] == 6'd0) begin
            // block full: compress, pad afterwards if this was the last beat
            cmp_ctl.start = 1'b1;
            pad_mode_nxt  = 1'b0;
            finishing_nxt = in_data.last_byte;
            state_nxt     = S_CMP;
          end else if (in_data.last_byte) begin
            pad_idx_nxt   = cnt_inc[5:2];
            pad_first_nxt = 1'b1;
            len_phase_nxt = (cnt_inc[5:2] < LEN_WORD);
            pad_mode_nxt  = 1'b1;
            state_nxt     = S_PADW;
          end
        end
      end
      S_PADW: begin
        pad_first_nxt = 1'b0;
        if (pad_idx_r == LAST_WORD) begin
          cmp_ctl.start = 1'b1;
          final_blk_nxt = len_phase_r;
          state_nxt     = S_CMP;
        end else begin
          pad_idx_nxt = pad_idx_r + BUF_AW'(1);
        end
      end
      S_CMP: begin
        if (cmp_stat.done) begin
          chain_nxt = cmp_sum;
          if (pad_mode_r) begin
            if (final_blk_r) begin
              state_nxt = S_OUT;
            end else begin
              // length did not fit: one more block of zeros and length
              pad_idx_nxt   = '0;
              pad_first_nxt = 1'b0;
              len_phase_nxt = 1'b1;
              state_nxt     = S_PADW;
            end
          end else if (finishing_r) begin
            pad_idx_nxt   = '0;
            pad_first_nxt = 1'b1;
            len_phase_nxt = 1'b1;
            pad_mode_nxt  = 1'b1;
            state_nxt     = S_PADW;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        // hold the digest until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_nxt.digest_low      = {chain_r[1], chain_r[0]};
          out_nxt.digest_high     = {chain_r[3], chain_r[2]};
          out_nxt.length_overflow = ovf_r;
          out_valid_nxt  = 1'b1;
          chain_nxt      = MD5_INIT;
          byte_count_nxt = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      byte_count_r <= '0;
      ovf_r        <= 1'b0;
      mode_r       <= 1'b0;
      chain_r      <= MD5_INIT;
      pad_idx_r    <= '0;
      pad_first_r  <= 1'b0;
      len_phase_r  <= 1'b0;
      pad_mode_r   <= 1'b0;
      finishing_r  <= 1'b0;
      final_blk_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      ovf_r        <= ovf_nxt;
      mode_r       <= mode_nxt;
      chain_r      <= chain_nxt;
      pad_idx_r    <= pad_idx_nxt;
      pad_first_r  <= pad_first_nxt;
      len_phase_r  <= len_phase_nxt;
      pad_mode_r   <= pad_mode_nxt;
      finishing_r  <= finishing_nxt;
      final_blk_r  <= final_blk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  smd5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUF_WORDS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmp_stat.rd_en),
    .raddr (cmp_stat.rd_addr),
    .rdata (ram_rdata)
  );

  smd5_compress u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cmp_ctl),
    .chain_in (chain_r),
    .rdata    (ram_rdata),
    .stat     (cmp_stat),
    .sum      (cmp_sum)
  );

  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && cmp_stat.rd_en && ram_waddr == cmp_stat.rd_addr))
    else $error("buffer read and write hit the same word");

  a_no_accept_while_hashing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !cmp_stat.busy)
    else $error("character beat taken while compression runs");

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_stat.done |-> (state_r == S_CMP))
    else $error("compression finished outside the wait state");

  a_pad_end_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PADW && pad_idx_r == LAST_WORD) |=> cmp_stat.busy)
    else $error("padding block written but compression not started");

endmodule

@@ dv/smd5_digest_checker.sv @@
// Scoreboard for serial_md5_key_derive_core: mirrors character mapping, transform and MD5.
// Watches the in, out and cfg channels; needs only the type definitions in smd5_pkg.
`timescale 1ns / 1ps
module smd5_digest_checker
  import smd5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_derive_mode,
  output int        fail_count,
  output int        digests_pending,
  output int        digests_checked
);

  localparam logic [7:0] ASC_0       = 8'h30;
  localparam logic [7:0] ASC_9       = 8'h39;
  localparam logic [7:0] ASC_UA      = 8'h41;
  localparam logic [7:0] ASC_UZ      = 8'h5A;
  localparam logic [7:0] ASC_LA      = 8'h61;
  localparam logic [7:0] ASC_LZ      = 8'h7A;
  localparam logic [7:0] UP_SHIFT    = 8'h37;
  localparam logic [7:0] LO_SHIFT    = 8'h57;
  localparam logic [7:0] IV_SCALE    = 8'd17;
  localparam logic [7:0] IV_BIAS     = 8'h13;
  localparam logic [7:0] KEY_SCALE   = 8'd13;
  localparam logic [7:0] KEY_BIAS    = 8'd61;
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [127:0] CHAIN_SEED =
    {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [0:63][31:0] SINE_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [0:15][4:0] SHIFT_AMT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Shadow of the block's hashing state, bytes of the block little-endian in blk_q
  logic [511:0] blk_q;
  logic [127:0] chain_q;
  logic [15:0]  count_q;
  logic         ovf_q;
  logic         mode_q;
  out_item_t    digest_q[$];
  out_item_t    want;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (32 - int'(s)));
  endfunction

  function automatic logic [127:0] md5_block(input logic [127:0] h, input logic [511:0] blk);
    logic [31:0] a, b, c, d, f, hold;
    int gi;
    a = h[31:0];
    b = h[63:32];
    c = h[95:64];
    d = h[127:96];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f  = (b & c) | (~b & d);
          gi = i;
        end
        1: begin
          f  = (d & b) | (~d & c);
          gi = 5 * i + 1;
        end
        2: begin
          f  = b ^ c ^ d;
          gi = 3 * i + 5;
        end
        default: begin
          f  = c ^ (b | ~d);
          gi = 7 * i;
        end
      endcase
      gi   = gi & 15;
      hold = d;
      d    = c;
      c    = b;
      b    = b + rotl(a + f + SINE_K[i] + blk[32*gi +: 32], SHIFT_AMT[(i / 16) * 4 + (i % 4)]);
      a    = hold;
    end
    return {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};
  endfunction

  function automatic logic [7:0] char_weight(input logic [7:0] ch, input logic key_sel);
    logic [7:0] v;
    v = ch;
    if (ch >= ASC_0 && ch <= ASC_9) v = ch - ASC_0;
    else if (ch >= ASC_UA && ch <= ASC_UZ) v = ch - UP_SHIFT;
    else if (ch >= ASC_LA && ch <= ASC_LZ) v = ch - LO_SHIFT;
    return key_sel ? 8'(v * KEY_SCALE + KEY_BIAS) : 8'(v * IV_SCALE + IV_BIAS);
  endfunction

  task automatic absorb_char(input logic [7:0] ch, input logic is_last);
    logic [31:0] bitlen;
    int pos;
    blk_q[8*count_q[5:0] +: 8] = char_weight(ch, mode_q);
    if (count_q == 16'hFFFF) ovf_q = 1'b1;
    count_q = count_q + 16'd1;
    if (count_q[5:0] == 6'd0) chain_q = md5_block(chain_q, blk_q);
    if (is_last) begin
      // pad, append bit length of the (possibly wrapped) count, close the hash
      pos    = count_q[5:0];
      bitlen = {13'd0, count_q, 3'b000};
      blk_q[8*pos +: 8] = PAD_MARK;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk_q[8*pos +: 8] = 8'h00;
          pos++;
        end
        chain_q = md5_block(chain_q, blk_q);
        pos = 0;
      end
      while (pos < 56) begin
        blk_q[8*pos +: 8] = 8'h00;
        pos++;
      end
      blk_q[511:448] = {32'd0, bitlen};
      chain_q = md5_block(chain_q, blk_q);
      digest_q.push_back({chain_q[63:0], chain_q[127:64], ovf_q});
      chain_q = CHAIN_SEED;
      count_q = '0;
      ovf_q   = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      blk_q           = '0;
      chain_q         = CHAIN_SEED;
      count_q         = '0;
      ovf_q           = 1'b0;
      mode_q          = 1'b0;
      fail_count      = 0;
      digests_checked = 0;
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("digest beat with nothing expected: %h %h %b",
                 out_data.digest_low, out_data.digest_high, out_data.length_overflow);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          digests_checked++;
          if (out_data.digest_low !== want.digest_low) begin
            $error("digest_low: expected %h, got %h", want.digest_low, out_data.digest_low);
            fail_count++;
          end
          if (out_data.digest_high !== want.digest_high) begin
            $error("digest_high: expected %h, got %h", want.digest_high, out_data.digest_high);
            fail_count++;
          end
          if (out_data.length_overflow !== want.length_overflow) begin
            $error("length_overflow: expected %b, got %b",
                   want.length_overflow, out_data.length_overflow);
            fail_count++;
          end
        end
      end
      // the character on this edge still uses the old mode
      if (in_valid && in_ready) absorb_char(in_data.char_byte, in_data.last_byte);
      if (cfg_valid && cfg_ready) mode_q = cfg_derive_mode;
    end
    digests_pending = digest_q.size();
  end

endmodule

@@ dv/tb_serial_md5_key_derive_core.sv @@
// Top of the serial MD5 key derivation testbench: clock, reset, stimulus and verdict.
// Instantiates serial_md5_key_derive_core and smd5_digest_checker; uses smd5_pkg types.
`timescale 1ns / 1ps
module tb_serial_md5_key_derive_core;
  import smd5_pkg::*;

  localparam logic MODE_IV      = 1'b0;
  localparam logic MODE_KEY     = 1'b1;
  localparam int   HOLD_CYCLES  = 1500;
  localparam int   DRAIN_CYCLES = 300;
  localparam int   RANDOM_CHARS = 1150;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_derive_mode;

  int fail_count;
  int digests_pending;
  int digests_checked;

  bit send_gaps;
  bit recv_gaps;
  bit hold_req;
  bit hold_done;
  int chars_sent;
  int serials_sent;

  serial_md5_key_derive_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_derive_mode (cfg_derive_mode)
  );

  smd5_digest_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_derive_mode (cfg_derive_mode),
    .fail_count      (fail_count),
    .digests_pending (digests_pending),
    .digests_checked (digests_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Digest sink: random stalls, plus one long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        hold_done = 1'b1;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_char();
    logic [7:0] edge_vals [16];
    int r;
    edge_vals = '{8'h00, 8'hFF, 8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41,
                  8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h7F, 8'h80};
    r = $urandom_range(0, 9);
    if (r < 2) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 4) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 5) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 8) return 8'($urandom_range(0, 255));
    return edge_vals[$urandom_range(0, 15)];
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 16);
    if (r < 80) return $urandom_range(52, 70);
    if (r < 90) return $urandom_range(120, 136);
    return $urandom_range(1, 3);
  endfunction

  task automatic put_char(input logic [7:0] ch, input logic last);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {ch, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    if (last) serials_sent++;
  endtask

  task automatic send_serial(input int len);
    for (int k = 0; k < len; k++) put_char(pick_char(), k == len - 1);
  endtask

  // Drop valid, wait for every digest, then let the block run dry
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digests_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_derive_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rand_base;
    int phase_msgs;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_derive_mode = 1'b0;
    send_gaps       = 1'b0;
    recv_gaps       = 1'b0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    chars_sent      = 0;
    serials_sent    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: class boundaries of the character map, both transforms
    write_mode(MODE_IV);
    put_char(8'h30, 1'b1);
    put_char(8'h39, 1'b0);
    put_char(8'h41, 1'b0);
    put_char(8'h5A, 1'b0);
    put_char(8'h61, 1'b0);
    put_char(8'h7A, 1'b1);
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(8'h2F, 1'b0);
    put_char(8'h3A, 1'b0);
    put_char(8'h40, 1'b0);
    put_char(8'h5B, 1'b0);
    put_char(8'h60, 1'b0);
    put_char(8'h7B, 1'b1);
    write_mode(MODE_KEY);
    put_char(8'hFF, 1'b1);
    put_char(8'h00, 1'b1);
    // switch the transform in the middle of a serial
    put_char(8'h6B, 1'b0);
    put_char(8'h33, 1'b0);
    write_mode(MODE_IV);
    put_char(8'h51, 1'b0);
    put_char(8'h80, 1'b1);
    settle();

    // Random serials; idling stops for the tail of the run
    rand_base = chars_sent;
    while (chars_sent - rand_base < RANDOM_CHARS) begin
      if ($urandom_range(0, 1) == 1) write_mode(1'($urandom_range(0, 1)));
      send_gaps = (chars_sent - rand_base) < (RANDOM_CHARS * 85) / 100;
      recv_gaps = send_gaps;
      if (!hold_done && !hold_req && chars_sent - rand_base > 300) begin
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++) send_serial($urandom_range(1, 6));
      end
      phase_msgs = $urandom_range(4, 10);
      for (int k = 0; k < phase_msgs; k++) send_serial(pick_len());
    end
    settle();

    $display("Summary: %0d serials of %0d characters, %0d digests compared.",
             serials_sent, chars_sent, digests_checked);
    $display("Covered: both transforms, mid-serial mode switch, padding edges, output stall.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/smd5_pkg.sv
design/smd5_ram.sv
design/smd5_compress.sv
design/serial_md5_key_derive_core.sv
dv/smd5_digest_checker.sv
dv/tb_serial_md5_key_derive_core.sv
